[sv/tcm_pkg.sv]
// ----------------------------------------------------------------------------
// tcm_pkg: shared types and constants of the touch calibration mapper
// Register indexes, reset values, widths and the record passed between
// divider cells.
// ----------------------------------------------------------------------------
package tcm_pkg;

    localparam int unsigned VAL_W  = 12;
    localparam int unsigned QUOT_W = 12;
    // Numerator (v - segment start) * half fits in 12 + 11 bits.
    localparam int unsigned NUM_W  = 23;

    localparam int unsigned DEF_SCREEN_WIDTH  = 800;
    localparam int unsigned DEF_SCREEN_HEIGHT = 480;

    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X    = 3'd0,
        REG_ORIGIN_Y    = 3'd1,
        REG_MID_X       = 3'd2,
        REG_MID_Y       = 3'd3,
        REG_FAR_X       = 3'd4,
        REG_FAR_Y       = 3'd5,
        REG_PASSTHROUGH = 3'd6
    } t_reg_idx;

    localparam logic [VAL_W-1:0] RST_ORIGIN = 12'd200;
    localparam logic [VAL_W-1:0] RST_MID    = 12'd2048;
    localparam logic [VAL_W-1:0] RST_FAR    = 12'd3900;

    // One axis moving down the divider chain.
    typedef struct packed {
        logic [NUM_W-1:0]  rem;    // partial remainder / remaining numerator bits
        logic [VAL_W-1:0]  div;    // divisor (segment span)
        logic [QUOT_W-1:0] quo;    // quotient bits so far
        logic [VAL_W-1:0]  base;   // pixel added to the quotient
        logic              bypass; // result already final in base
    } t_axis;

    typedef struct packed {
        logic  vld;
        logic  point_valid;
        t_axis ax;
        t_axis ay;
    } t_item;

endpackage

[sv/tcm_prep.sv]
// ----------------------------------------------------------------------------
// tcm_prep: segment selection for one axis
// Picks the segment, clamps, and forms numerator, divisor and base pixel.
// ----------------------------------------------------------------------------
module tcm_prep #(
    parameter int unsigned SIZE = tcm_pkg::DEF_SCREEN_WIDTH
) (
    input  logic [tcm_pkg::VAL_W-1:0] i_v,
    input  logic [tcm_pkg::VAL_W-1:0] i_o,
    input  logic [tcm_pkg::VAL_W-1:0] i_m,
    input  logic [tcm_pkg::VAL_W-1:0] i_f,
    input  logic                      i_pass,
    input  logic                      i_valid,
    output tcm_pkg::t_axis            o_ax
);
    localparam logic [tcm_pkg::VAL_W-1:0] SZ   = tcm_pkg::VAL_W'(SIZE);
    localparam logic [tcm_pkg::VAL_W-1:0] HALF = tcm_pkg::VAL_W'(SIZE / 2);

    logic [tcm_pkg::VAL_W-1:0] diff;
    logic [tcm_pkg::NUM_W-1:0] prod;

    always_comb begin
        o_ax = '0;
        diff = '0;
        if (!i_valid) begin
            o_ax.bypass = 1'b1;
        end else if (i_pass) begin
            o_ax.bypass = 1'b1;
            o_ax.base   = i_v;
        end else if (i_v > i_m) begin
            diff       = i_v - i_m;
            o_ax.div   = i_f - i_m;
            o_ax.base  = HALF;
            if (i_v > i_f) begin
                o_ax.bypass = 1'b1;
                o_ax.base   = SZ;
            end else if (i_f <= i_m) begin
                o_ax.bypass = 1'b1;
            end
        end else begin
            diff     = i_v - i_o;
            o_ax.div = i_m - i_o;
            if (i_v < i_o || i_m <= i_o) begin
                o_ax.bypass = 1'b1;
            end
        end
        prod     = tcm_pkg::NUM_W'(diff) * tcm_pkg::NUM_W'(HALF);
        o_ax.rem = o_ax.bypass ? '0 : prod;
    end
endmodule

[sv/tcm_cell.sv]
// ----------------------------------------------------------------------------
// tcm_cell: one restoring-division cell
// Resolves quotient bit BIT for both axes and hands the item to the next cell.
// ----------------------------------------------------------------------------
module tcm_cell #(
    parameter int unsigned BIT = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tcm_pkg::t_item i_item,
    output tcm_pkg::t_item o_item
);
    localparam int unsigned NW = tcm_pkg::NUM_W;

    tcm_pkg::t_item r_item, n_item;

    function automatic tcm_pkg::t_axis step(input tcm_pkg::t_axis a);
        tcm_pkg::t_axis r;
        logic [NW+tcm_pkg::VAL_W-1:0] d_sh;
        r    = a;
        d_sh = (NW + tcm_pkg::VAL_W)'(a.div) << BIT;
        if ((NW + tcm_pkg::VAL_W)'(a.rem) >= d_sh) begin
            r.rem = a.rem - NW'(d_sh);
            r.quo[BIT] = 1'b1;
        end
        return r;
    endfunction

    always_comb begin
        n_item    = i_item;
        n_item.ax = step(i_item.ax);
        n_item.ay = step(i_item.ay);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else begin
            r_item.vld <= n_item.vld;
        end
        r_item.point_valid <= n_item.point_valid;
        r_item.ax          <= n_item.ax;
        r_item.ay          <= n_item.ay;
    end

    assign o_item = r_item;
endmodule

[sv/touch_calibration_mapper.sv]
// ----------------------------------------------------------------------------
// touch_calibration_mapper: two-segment touch calibration to screen pixels
// A started item passes one input register, twelve division cells and one output
// register before o_done rises with its result. Throughput: one item per cycle;
// every division cell takes a new item each cycle, so busy is always low and the
// receiver cannot stall.
// Synchronous active-low reset clears the pipeline and restores registers.
// ----------------------------------------------------------------------------
module touch_calibration_mapper #(
    parameter int unsigned SCREEN_WIDTH  = tcm_pkg::DEF_SCREEN_WIDTH,
    parameter int unsigned SCREEN_HEIGHT = tcm_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_reading_valid,
    input  logic [tcm_pkg::VAL_W-1:0]     i_raw_x,
    input  logic [tcm_pkg::VAL_W-1:0]     i_raw_y,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tcm_pkg::VAL_W-1:0]     i_cfg_data,
    output logic                          o_done,
    output logic                          o_point_valid,
    output logic [tcm_pkg::VAL_W-1:0]     o_screen_x,
    output logic [tcm_pkg::VAL_W-1:0]     o_screen_y
);
    localparam int unsigned NC = tcm_pkg::QUOT_W;

    logic [tcm_pkg::VAL_W-1:0] r_ox, r_oy, r_mx, r_my, r_fx, r_fy;
    logic                      r_pass;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox   <= tcm_pkg::RST_ORIGIN;
            r_oy   <= tcm_pkg::RST_ORIGIN;
            r_mx   <= tcm_pkg::RST_MID;
            r_my   <= tcm_pkg::RST_MID;
            r_fx   <= tcm_pkg::RST_FAR;
            r_fy   <= tcm_pkg::RST_FAR;
            r_pass <= 1'b0;
        end else if (i_cfg_valid) begin
            case (tcm_pkg::t_reg_idx'(i_cfg_index))
                tcm_pkg::REG_ORIGIN_X:    r_ox   <= i_cfg_data;
                tcm_pkg::REG_ORIGIN_Y:    r_oy   <= i_cfg_data;
                tcm_pkg::REG_MID_X:       r_mx   <= i_cfg_data;
                tcm_pkg::REG_MID_Y:       r_my   <= i_cfg_data;
                tcm_pkg::REG_FAR_X:       r_fx   <= i_cfg_data;
                tcm_pkg::REG_FAR_Y:       r_fy   <= i_cfg_data;
                tcm_pkg::REG_PASSTHROUGH: r_pass <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tcm_pkg::t_axis n_ax, n_ay;
    tcm_pkg::t_item r_in;

    tcm_prep #(.SIZE(SCREEN_WIDTH)) u_prep_x (
        .i_v(i_raw_x), .i_o(r_ox), .i_m(r_mx), .i_f(r_fx),
        .i_pass(r_pass), .i_valid(i_reading_valid), .o_ax(n_ax)
    );
    tcm_prep #(.SIZE(SCREEN_HEIGHT)) u_prep_y (
        .i_v(i_raw_y), .i_o(r_oy), .i_m(r_my), .i_f(r_fy),
        .i_pass(r_pass), .i_valid(i_reading_valid), .o_ax(n_ay)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.vld <= 1'b0;
        end else begin
            r_in.vld <= start;
        end
        r_in.point_valid <= i_reading_valid;
        r_in.ax          <= n_ax;
        r_in.ay          <= n_ay;
    end

    // Cell k resolves quotient bit NC-1-k, most significant first.
    tcm_pkg::t_item chain [NC+1];
    assign chain[0] = r_in;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        tcm_cell #(.BIT(NC - 1 - k)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_item(chain[k]), .o_item(chain[k+1])
        );
    end

    logic r_done, r_pv;
    logic [tcm_pkg::VAL_W-1:0] r_sx, r_sy;
    tcm_pkg::t_item last;
    assign last = chain[NC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= last.vld;
        end
        r_pv <= last.point_valid;
        r_sx <= last.ax.bypass ? last.ax.base : last.ax.base + last.ax.quo;
        r_sy <= last.ay.bypass ? last.ay.base : last.ay.base + last.ay.quo;
    end

    assign o_done        = r_done;
    assign o_point_valid = r_pv;
    assign o_screen_x    = r_sx;
    assign o_screen_y    = r_sy;
endmodule

[sv/tcm_checker.sv]
// ----------------------------------------------------------------------------
// tcm_checker: port-level checks of the touch calibration mapper
// Watches latency, result shape and the always-ready handshakes.
// ----------------------------------------------------------------------------
module tcm_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      i_reading_valid,
    input logic                      o_cfg_ready,
    input logic                      o_done,
    input logic                      o_point_valid,
    input logic [tcm_pkg::VAL_W-1:0] o_screen_x,
    input logic [tcm_pkg::VAL_W-1:0] o_screen_y
);
    // An item taken at start leaves with o_done after the input, cell and output registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##14 o_done)
        else $error("item did not complete after fourteen cycles");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_point_valid |-> o_screen_x == '0 && o_screen_y == '0)
        else $error("invalid reading gave a nonzero point");

    a_valid_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##14 o_point_valid == $past(i_reading_valid, 14))
        else $error("point valid flag does not follow the reading");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && o_cfg_ready)
        else $error("block stalled an input");
endmodule

bind touch_calibration_mapper tcm_checker u_tcm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .i_reading_valid(i_reading_valid), .o_cfg_ready(o_cfg_ready),
    .o_done(o_done), .o_point_valid(o_point_valid),
    .o_screen_x(o_screen_x), .o_screen_y(o_screen_y)
);

[sim/touch_calibration_mapper_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_calibration_mapper_tb: self-checking bench for the touch mapper
// Drives touch readings through the command handshake and predicts each point
// from the calibration registers. Directed rows cover reset values and field
// extremes; directed phases cover passthrough and degenerate spans. Random phases
// then load new calibrations and check every reported point in order.
// ----------------------------------------------------------------------------
module touch_calibration_mapper_tb;
    localparam int unsigned VAL_W        = tcm_pkg::VAL_W;
    localparam int unsigned CFG_IDX_W    = tcm_pkg::CFG_IDX_W;
    localparam int unsigned WIDTH_PX     = tcm_pkg::DEF_SCREEN_WIDTH;
    localparam int unsigned HEIGHT_PX    = tcm_pkg::DEF_SCREEN_HEIGHT;
    localparam int unsigned SETTLE_CYC   = 30;
    localparam int unsigned STALL_LIMIT  = 3000;
    localparam int unsigned RAND_PHASES  = 6;
    localparam int unsigned PHASE_ITEMS  = 90;
    // An index past the register list; the block must ignore such writes.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic             pv;
        logic [VAL_W-1:0] sx;
        logic [VAL_W-1:0] sy;
    } t_point;

    typedef struct {
        logic             valid;
        logic [VAL_W-1:0] rx;
        logic [VAL_W-1:0] ry;
        bit               typed;
        logic [VAL_W-1:0] ex;
        logic [VAL_W-1:0] ey;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_reading_valid = 1'b0;
    logic [VAL_W-1:0]     i_raw_x = '0;
    logic [VAL_W-1:0]     i_raw_y = '0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [VAL_W-1:0]     i_cfg_data = '0;
    logic                 o_done;
    logic                 o_point_valid;
    logic [VAL_W-1:0]     o_screen_x;
    logic [VAL_W-1:0]     o_screen_y;

    // Calibration as the bench believes it to be.
    logic [VAL_W-1:0] cal_org_x = tcm_pkg::RST_ORIGIN, cal_org_y = tcm_pkg::RST_ORIGIN;
    logic [VAL_W-1:0] cal_mid_x = tcm_pkg::RST_MID, cal_mid_y = tcm_pkg::RST_MID;
    logic [VAL_W-1:0] cal_far_x = tcm_pkg::RST_FAR, cal_far_y = tcm_pkg::RST_FAR;
    logic             cal_raw = 1'b0;

    t_point pending_points[$];
    int     errors = 0;
    int     stall_cycles = 0;
    bit     no_gaps = 1'b0;

    touch_calibration_mapper uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_reading_valid(i_reading_valid), .i_raw_x(i_raw_x), .i_raw_y(i_raw_y),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_done(o_done), .o_point_valid(o_point_valid),
        .o_screen_x(o_screen_x), .o_screen_y(o_screen_y)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [VAL_W-1:0] axis_pixel(input int unsigned v, o, m, f, s);
        int unsigned half;
        half = s / 2;
        if (v > m) begin
            if (v > f) return VAL_W'(s);
            if (f <= m) return VAL_W'(half);
            return VAL_W'(half + (v - m) * half / (f - m));
        end
        if (v < o || m <= o) return '0;
        return VAL_W'((v - o) * half / (m - o));
    endfunction

    function automatic t_point touch_point(input logic v, input logic [VAL_W-1:0] x, y);
        t_point p;
        p.pv = v;
        p.sx = '0;
        p.sy = '0;
        if (v && cal_raw) begin
            p.sx = x;
            p.sy = y;
        end else if (v) begin
            p.sx = axis_pixel(x, cal_org_x, cal_mid_x, cal_far_x, WIDTH_PX);
            p.sy = axis_pixel(y, cal_org_y, cal_mid_y, cal_far_y, HEIGHT_PX);
        end
        return p;
    endfunction

    // Outputs and handshakes are sampled at the falling edge, away from the
    // rising edge where both sides update.
    always @(negedge i_clk) begin
        t_point exp_pt;
        if (i_rst_n) begin
            if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("touch_calibration_mapper verification failed");
                $finish;
            end
            if (o_done) begin
                if (pending_points.size() == 0) begin
                    $display("%0t: unexpected point pv=%0d x=%0d y=%0d", $time,
                             o_point_valid, o_screen_x, o_screen_y);
                    errors++;
                end else begin
                    exp_pt = pending_points.pop_front();
                    if (o_point_valid !== exp_pt.pv) begin
                        $display("%0t: point_valid expected %0d actual %0d", $time,
                                 exp_pt.pv, o_point_valid);
                        errors++;
                    end
                    if (o_screen_x !== exp_pt.sx) begin
                        $display("%0t: screen_x expected %0d actual %0d", $time,
                                 exp_pt.sx, o_screen_x);
                        errors++;
                    end
                    if (o_screen_y !== exp_pt.sy) begin
                        $display("%0t: screen_y expected %0d actual %0d", $time,
                                 exp_pt.sy, o_screen_y);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic send_reading(input logic v, input logic [VAL_W-1:0] x, y,
                                input bit typed, input logic [VAL_W-1:0] ex, ey);
        int     gap;
        logic   was_busy;
        t_point p;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_reading_valid <= v;
        i_raw_x <= x;
        i_raw_y <= y;
        do begin
            @(negedge i_clk);
            was_busy = busy;
            @(posedge i_clk);
        end while (was_busy);
        p = touch_point(v, x, y);
        if (typed) begin
            p.sx = ex;
            p.sy = ey;
        end
        pending_points.push_back(p);
    endtask

    // Leaves i_cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        logic was_ready;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do begin
            @(negedge i_clk);
            was_ready = o_cfg_ready;
            @(posedge i_clk);
        end while (!was_ready);
        case (idx)
            tcm_pkg::REG_ORIGIN_X:    cal_org_x = data;
            tcm_pkg::REG_ORIGIN_Y:    cal_org_y = data;
            tcm_pkg::REG_MID_X:       cal_mid_x = data;
            tcm_pkg::REG_MID_Y:       cal_mid_y = data;
            tcm_pkg::REG_FAR_X:       cal_far_x = data;
            tcm_pkg::REG_FAR_Y:       cal_far_y = data;
            tcm_pkg::REG_PASSTHROUGH: cal_raw = data[0];
            default: ;
        endcase
    endtask

    task automatic load_calibration(input logic [VAL_W-1:0] ox, oy, mx, my, fx, fy,
                                    input logic raw);
        write_reg(tcm_pkg::REG_ORIGIN_X, ox);
        write_reg(tcm_pkg::REG_ORIGIN_Y, oy);
        write_reg(tcm_pkg::REG_MID_X, mx);
        write_reg(tcm_pkg::REG_MID_Y, my);
        write_reg(tcm_pkg::REG_FAR_X, fx);
        write_reg(tcm_pkg::REG_FAR_Y, fy);
        write_reg(tcm_pkg::REG_PASSTHROUGH, {{(VAL_W-1){1'b0}}, raw});
        i_cfg_valid <= 1'b0;
    endtask

    // Lets every expected point come out, then a little more.
    task automatic drain();
        start <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] near_value(input logic [VAL_W-1:0] o, m, f);
        case ($urandom_range(0, 5))
            0: return VAL_W'(o + $urandom_range(0, 2) - 1);
            1: return VAL_W'(m + $urandom_range(0, 2) - 1);
            2: return VAL_W'(f + $urandom_range(0, 2) - 1);
            3: return $urandom_range(0, 1) ? 12'd0 : 12'hFFF;
            default: return VAL_W'($urandom_range(0, 4095));
        endcase
    endfunction

    t_row rows[] = '{
        '{1'b0, 12'd1234, 12'd3000, 1'b1, 12'd0, 12'd0},
        '{1'b0, 12'hFFF, 12'hFFF, 1'b1, 12'd0, 12'd0},
        '{1'b1, 12'd0, 12'd0, 1'b1, 12'd0, 12'd0},
        '{1'b1, 12'hFFF, 12'hFFF, 1'b1, 12'd800, 12'd480},
        '{1'b1, 12'd200, 12'd200, 1'b1, 12'd0, 12'd0},
        '{1'b1, 12'd2048, 12'd2048, 1'b1, 12'd400, 12'd240},
        '{1'b1, 12'd3900, 12'd3900, 1'b1, 12'd800, 12'd480},
        '{1'b1, 12'd3901, 12'd199, 1'b1, 12'd800, 12'd0},
        '{1'b1, 12'd1000, 12'd3000, 1'b0, 12'd0, 12'd0},
        '{1'b1, 12'd2049, 12'd2047, 1'b0, 12'd0, 12'd0},
        '{1'b1, 12'd201, 12'd3899, 1'b0, 12'd0, 12'd0},
        '{1'b1, 12'hAAA, 12'h555, 1'b0, 12'd0, 12'd0}
    };

    initial begin
        logic [VAL_W-1:0] c[6];
        logic [VAL_W-1:0] x, y;
        int               n;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        no_gaps = 1'b1;
        foreach (rows[i])
            send_reading(rows[i].valid, rows[i].rx, rows[i].ry, rows[i].typed,
                         rows[i].ex, rows[i].ey);
        drain();

        // Passthrough reports raw values; an invalid reading still gives zeros.
        no_gaps = 1'b0;
        load_calibration(tcm_pkg::RST_ORIGIN, tcm_pkg::RST_ORIGIN, tcm_pkg::RST_MID,
                         tcm_pkg::RST_MID, tcm_pkg::RST_FAR, tcm_pkg::RST_FAR, 1'b1);
        send_reading(1'b1, 12'hFFF, 12'd0, 1'b1, 12'hFFF, 12'd0);
        send_reading(1'b1, 12'd0, 12'hFFF, 1'b1, 12'd0, 12'hFFF);
        send_reading(1'b0, 12'hFFF, 12'hFFF, 1'b1, 12'd0, 12'd0);
        drain();

        // Zero spans on X, reversed spans on Y, plus a write to no register.
        write_reg(REG_UNUSED, 12'hFFF);
        load_calibration(12'd1000, 12'd3000, 12'd1000, 12'd2000, 12'd1000, 12'd1000, 1'b0);
        send_reading(1'b1, 12'd1000, 12'd2500, 1'b0, 12'd0, 12'd0);
        send_reading(1'b1, 12'd1001, 12'd1999, 1'b0, 12'd0, 12'd0);
        send_reading(1'b1, 12'd999, 12'd3000, 1'b0, 12'd0, 12'd0);
        send_reading(1'b1, 12'hFFF, 12'd0, 1'b0, 12'd0, 12'd0);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            for (int k = 0; k < 6; k++) c[k] = VAL_W'($urandom_range(0, 4095));
            if (ph == 0) begin
                c = '{12'd0, 12'd0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF};
            end else if (ph == 1) begin
                c = '{12'hFFF, 12'hFFF, 12'd0, 12'd0, 12'd0, 12'd0};
            end else if (ph != 5) begin
                // Well-formed calibration: origin below mid below far.
                c[0] = VAL_W'($urandom_range(0, 1300));
                c[1] = VAL_W'($urandom_range(0, 1300));
                c[2] = VAL_W'($urandom_range(1400, 2700));
                c[3] = VAL_W'($urandom_range(1400, 2700));
                c[4] = VAL_W'($urandom_range(2800, 4095));
                c[5] = VAL_W'($urandom_range(2800, 4095));
            end
            load_calibration(c[0], c[1], c[2], c[3], c[4], c[5], ph == 4);
            no_gaps = (ph == 2);
            n = 0;
            while (n < PHASE_ITEMS) begin
                x = near_value(cal_org_x, cal_mid_x, cal_far_x);
                y = near_value(cal_org_y, cal_mid_y, cal_far_y);
                send_reading($urandom_range(0, 7) != 0, x, y, 1'b0, 12'd0, 12'd0);
                n++;
                if (n == PHASE_ITEMS / 2 && ph == 3) drain();
                if (n % 30 == 0) no_gaps = !no_gaps && ($urandom_range(0, 2) == 0);
            end
            drain();
        end

        if (errors == 0)
            $display("touch_calibration_mapper verification clean");
        else
            $display("touch_calibration_mapper verification failed");
        $finish;
    end
endmodule
